FILE: design/two_stack_deque_top_macros.svh
// ----------------------------------------------------------------------------
// two_stack_deque_top_macros.svh
// Assertion macros used by the deque checker.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_DEQUE_TOP_MACROS_SVH
`define TWO_STACK_DEQUE_TOP_MACROS_SVH

// clocked assertion, off while reset is asserted
`define TSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define TSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Types and constants of the two-stack deque.
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int SIDE_DEPTH = 256;
	localparam int DATA_WIDTH = 32;

	localparam int OP_W    = 2;
	localparam int WORD_W  = 32;
	localparam int POS_W   = 9;
	localparam int COUNT_W = 10;

	localparam int ADDR_W = $clog2(SIDE_DEPTH);
	localparam int FILL_W = $clog2(SIDE_DEPTH + 1);
	localparam int SUM_W  = FILL_W + 1;
	localparam int CMP_W  = (SUM_W > POS_W) ? SUM_W : POS_W;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_READ       = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		ST_IDLE   = 1'b0,
		ST_LOOKUP = 1'b1
	} state_t;

	typedef struct packed {
		logic accept;    // item taken: update stacks, start lookup
		logic load_out;  // capture result into the output register
	} tsd_cmd_t;

endpackage

FILE: design/two_stack_deque_top.sv
// ----------------------------------------------------------------------------
// two_stack_deque_top
// Double-ended queue built from a front and a back stack, push and index read.
// ----------------------------------------------------------------------------
// An item is accepted in the idle state: a push is written into its stack
// and the registered read of the addressed stack memory is launched. In
// the lookup state the result goes into the output register once it is
// free. A new item is taken while the previous result still waits there,
// but not while a lookup is pending. Every item returns one result; count,
// is_empty, front_value and back_value report the state after the item,
// and the end values read as zero while the deque is empty.
module two_stack_deque_top
	import tsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    op,
	input  logic [WORD_W-1:0]  data_in,
	input  logic [POS_W-1:0]   position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WORD_W-1:0]  read_value,
	output logic               index_miss,
	output logic               side_full,
	output logic [COUNT_W-1:0] count,
	output logic               is_empty,
	output logic [WORD_W-1:0]  front_value,
	output logic [WORD_W-1:0]  back_value
);

	tsd_cmd_t cmd;

	tsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tsd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.data_in     (data_in),
		.position    (position),
		.read_value  (read_value),
		.index_miss  (index_miss),
		.side_full   (side_full),
		.count       (count),
		.is_empty    (is_empty),
		.front_value (front_value),
		.back_value  (back_value)
	);

endmodule

FILE: design/tsd_ctrl.sv
// ----------------------------------------------------------------------------
// tsd_ctrl
// Handshake controller: accepts an item, waits for the lookup, loads result.
// ----------------------------------------------------------------------------
module tsd_ctrl
	import tsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output tsd_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOOKUP: begin
				cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/tsd_datapath.sv
// ----------------------------------------------------------------------------
// tsd_datapath
// Stack memories, fill counters, end-value registers and result register.
// ----------------------------------------------------------------------------
module tsd_datapath
	import tsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tsd_cmd_t           cmd,
	input  logic [OP_W-1:0]    op,
	input  logic [WORD_W-1:0]  data_in,
	input  logic [POS_W-1:0]   position,
	output logic [WORD_W-1:0]  read_value,
	output logic               index_miss,
	output logic               side_full,
	output logic [COUNT_W-1:0] count,
	output logic               is_empty,
	output logic [WORD_W-1:0]  front_value,
	output logic [WORD_W-1:0]  back_value
);

	// front stack is stored reversed: its top is the first element
	data_t front_mem [SIDE_DEPTH];
	data_t back_mem  [SIDE_DEPTH];

	logic [FILL_W-1:0] front_fill_q;
	logic [FILL_W-1:0] back_fill_q;

	// end values kept in registers so status needs no memory port
	data_t front_top_q;
	data_t front_bot_q;
	data_t back_top_q;
	data_t back_bot_q;

	data_t front_rd_q;
	data_t back_rd_q;
	logic  is_read_q;
	logic  oor_q;
	logic  full_q;
	logic  in_front_q;

	logic [WORD_W-1:0]  read_value_q;
	logic               index_miss_q;
	logic               side_full_q;
	logic [COUNT_W-1:0] count_q;
	logic               is_empty_q;
	logic [WORD_W-1:0]  front_value_q;
	logic [WORD_W-1:0]  back_value_q;

	op_t               op_in;
	data_t             value_in;
	logic [SUM_W-1:0]  total;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  total_c;
	logic [CMP_W-1:0]  ffill_c;
	logic              oor_in;
	logic              in_front;
	logic [ADDR_W-1:0] front_addr;
	logic [ADDR_W-1:0] back_addr;
	logic              front_full;
	logic              back_full;
	logic              front_push;
	logic              back_push;
	logic              is_read;
	data_t             elem;
	data_t             front_sel;
	data_t             back_sel;

	always_comb begin
		op_in      = op_t'(op);
		value_in   = DATA_WIDTH'(data_in);
		total      = SUM_W'(front_fill_q) + SUM_W'(back_fill_q);
		pos_c      = CMP_W'(position);
		total_c    = CMP_W'(total);
		ffill_c    = CMP_W'(front_fill_q);
		oor_in     = pos_c >= total_c;
		in_front   = pos_c < ffill_c;
		front_addr = ADDR_W'(ffill_c - pos_c - CMP_W'(1));
		back_addr  = ADDR_W'(pos_c - ffill_c);
		front_full = front_fill_q == FILL_W'(SIDE_DEPTH);
		back_full  = back_fill_q == FILL_W'(SIDE_DEPTH);
		front_push = 1'b0;
		back_push  = 1'b0;
		is_read    = 1'b0;
		case (op_in)
			OP_PUSH_FRONT: front_push = !front_full;
			OP_PUSH_BACK:  back_push  = !back_full;
			OP_READ:       is_read    = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && front_push)
			front_mem[front_fill_q[ADDR_W-1:0]] <= value_in;
		if (cmd.accept)
			front_rd_q <= front_mem[front_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && back_push)
			back_mem[back_fill_q[ADDR_W-1:0]] <= value_in;
		if (cmd.accept)
			back_rd_q <= back_mem[back_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_fill_q <= '0;
			back_fill_q  <= '0;
		end else if (cmd.accept) begin
			if (front_push) front_fill_q <= front_fill_q + FILL_W'(1);
			if (back_push)  back_fill_q  <= back_fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			is_read_q  <= is_read;
			oor_q      <= is_read && oor_in;
			full_q     <= (op_in == OP_PUSH_FRONT && front_full) ||
			              (op_in == OP_PUSH_BACK && back_full);
			in_front_q <= in_front;
			if (front_push) begin
				front_top_q <= value_in;
				if (front_fill_q == '0) front_bot_q <= value_in;
			end
			if (back_push) begin
				back_top_q <= value_in;
				if (back_fill_q == '0) back_bot_q <= value_in;
			end
		end
	end

	always_comb begin
		elem      = in_front_q ? front_rd_q : back_rd_q;
		front_sel = (front_fill_q != '0) ? front_top_q : back_bot_q;
		back_sel  = (back_fill_q != '0) ? back_top_q : front_bot_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_value_q  <= (is_read_q && !oor_q) ? WORD_W'(elem) : '0;
			index_miss_q  <= oor_q;
			side_full_q   <= full_q;
			count_q       <= COUNT_W'(total);
			is_empty_q    <= total == '0;
			front_value_q <= (total == '0) ? '0 : WORD_W'(front_sel);
			back_value_q  <= (total == '0) ? '0 : WORD_W'(back_sel);
		end
	end

	assign read_value  = read_value_q;
	assign index_miss  = index_miss_q;
	assign side_full   = side_full_q;
	assign count       = count_q;
	assign is_empty    = is_empty_q;
	assign front_value = front_value_q;
	assign back_value  = back_value_q;

endmodule

FILE: design/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks of the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_stack_deque_top_macros.svh"

module tsd_checker
	import tsd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [OP_W-1:0]    op,
	input logic [WORD_W-1:0]  data_in,
	input logic [POS_W-1:0]   position,
	input logic               out_valid,
	input logic               out_ready,
	input logic [WORD_W-1:0]  read_value,
	input logic               index_miss,
	input logic               side_full,
	input logic [COUNT_W-1:0] count,
	input logic               is_empty,
	input logic [WORD_W-1:0]  front_value,
	input logic [WORD_W-1:0]  back_value
);

	`TSD_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(op) && $stable(data_in) && $stable(position), "offered item changed before accept")
	`TSD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`TSD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(count) && $stable(read_value) && $stable(front_value) && $stable(back_value), "stalled result changed")
	`TSD_ASSERT(a_empty_count, out_valid |-> (is_empty == (count == '0)), "is_empty disagrees with count")
	`TSD_ASSERT(a_flags_excl, out_valid && (index_miss || side_full) |-> read_value == '0 && !(index_miss && side_full), "flagged item carries data")

endmodule

bind two_stack_deque_top tsd_checker u_tsd_checker (.*);

FILE: dv/two_stack_deque_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_deque_top_tb
// Self-checking bench for the two-stack deque: pushes at both ends and reads.
// ----------------------------------------------------------------------------
// A directed opening covers the empty deque, extreme values, all op codes and
// the front-only case. Random traffic then fills both sides to overflow.
// A scoreboard mirrors both stacks, predicts every result when its item is
// accepted and compares each returned result field by field. Both handshake
// sides idle at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module two_stack_deque_top_tb;
	import tsd_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 5;
	localparam int RANDOM_ITEMS    = 740;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int MAX_REPORTS     = 200;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic [WORD_W-1:0]  read_value;
		logic               index_miss;
		logic               side_full;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic [WORD_W-1:0]  front_value;
		logic [WORD_W-1:0]  back_value;
	} deque_status_t;

	class deque_scoreboard;
		data_t         front_mem [SIDE_DEPTH];
		data_t         back_mem [SIDE_DEPTH];
		int            front_fill;
		int            back_fill;
		deque_status_t pending_status [$];
		int            errors;
		int            results_seen;
		int            dropped_pushes;
		int            missed_reads;
		int            hits;
		int            peak_count;

		function new();
			foreach (front_mem[i]) begin
				front_mem[i] = '0;
				back_mem[i]  = '0;
			end
			front_fill = 0;
			back_fill  = 0;
		endfunction

		// logical index from the front; front stack is stored reversed
		function data_t element_at(int idx);
			if (idx < front_fill)
				return front_mem[front_fill - 1 - idx];
			return back_mem[idx - front_fill];
		endfunction

		function void note_item(logic [OP_W-1:0] code, logic [WORD_W-1:0] value,
				logic [POS_W-1:0] pos);
			deque_status_t want;
			int total;
			want = '0;
			case (code)
				OP_PUSH_FRONT: begin
					if (front_fill >= SIDE_DEPTH) begin
						want.side_full = 1'b1;
					end else begin
						front_mem[front_fill] = value[DATA_WIDTH-1:0];
						front_fill++;
					end
				end
				OP_PUSH_BACK: begin
					if (back_fill >= SIDE_DEPTH) begin
						want.side_full = 1'b1;
					end else begin
						back_mem[back_fill] = value[DATA_WIDTH-1:0];
						back_fill++;
					end
				end
				OP_READ: begin
					if (int'(pos) >= front_fill + back_fill) begin
						want.index_miss = 1'b1;
					end else begin
						want.read_value = WORD_W'(element_at(int'(pos)));
						hits++;
					end
				end
				default: ;
			endcase
			total         = front_fill + back_fill;
			want.count    = COUNT_W'(total);
			want.is_empty = (total == 0);
			if (total != 0) begin
				// one side empty: the end value comes from the other stack's bottom
				want.front_value = WORD_W'(front_fill != 0 ? front_mem[front_fill - 1]
						: back_mem[0]);
				want.back_value  = WORD_W'(back_fill != 0 ? back_mem[back_fill - 1]
						: front_mem[0]);
			end
			if (want.side_full)
				dropped_pushes++;
			if (want.index_miss)
				missed_reads++;
			if (total > peak_count)
				peak_count = total;
			pending_status.insert(pending_status.size(), want);
		endfunction

		task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: result %0d %s: got %0h, expected %0h",
						$time, results_seen, field, got, want);
		endtask

		task check_result(deque_status_t got);
			deque_status_t want;
			results_seen++;
			if (pending_status.size() == 0) begin
				report("arrived with nothing pending", WORD_W'(got.count), '0);
				return;
			end
			want = pending_status.pop_front();
			if (got.read_value !== want.read_value)
				report("read_value", got.read_value, want.read_value);
			if (got.index_miss !== want.index_miss)
				report("index_miss", WORD_W'(got.index_miss), WORD_W'(want.index_miss));
			if (got.side_full !== want.side_full)
				report("side_full", WORD_W'(got.side_full), WORD_W'(want.side_full));
			if (got.count !== want.count)
				report("count", WORD_W'(got.count), WORD_W'(want.count));
			if (got.is_empty !== want.is_empty)
				report("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
			if (got.front_value !== want.front_value)
				report("front_value", got.front_value, want.front_value);
			if (got.back_value !== want.back_value)
				report("back_value", got.back_value, want.back_value);
		endtask
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [OP_W-1:0]    op           = '0;
	logic [WORD_W-1:0]  data_in      = '0;
	logic [POS_W-1:0]   position     = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [WORD_W-1:0]  read_value;
	logic               index_miss;
	logic               side_full;
	logic [COUNT_W-1:0] count;
	logic               is_empty;
	logic [WORD_W-1:0]  front_value;
	logic [WORD_W-1:0]  back_value;

	deque_scoreboard sb = new();
	int front_sent;
	int back_sent;
	int accepted_items;

	two_stack_deque_top u_dut (.*);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom();
	endfunction

	task automatic send_item(input logic [OP_W-1:0] code, input logic [WORD_W-1:0] value,
			input logic [POS_W-1:0] pos, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		data_in  <= value;
		position <= pos;
		do @(posedge clk); while (!in_ready);
		if (code == OP_PUSH_FRONT && front_sent < SIDE_DEPTH)
			front_sent++;
		if (code == OP_PUSH_BACK && back_sent < SIDE_DEPTH)
			back_sent++;
	endtask

	// both handshakes sampled at the edge, before any update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_item(op, data_in, position);
				accepted_items++;
			end
			if (out_valid && out_ready)
				sb.check_result({read_value, index_miss, side_full, count, is_empty,
						front_value, back_value});
		end
	end

	// receiver: random stalls, free-running stretches, one long hold-off
	initial begin
		bit held;
		int free_run;
		int gap;
		held     = 1'b0;
		free_run = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sb.results_seen >= 250) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (free_run > 0) begin
				free_run--;
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				if ($urandom_range(0, 99) < 3)
					free_run = $urandom_range(30, 120);
				gap = idle_len();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("two_stack_deque_top_tb: done, errors");
		$finish;
	end

	initial begin
		int r;
		int total;
		int gap;
		logic [OP_W-1:0] code;
		logic [POS_W-1:0] pos;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: reads miss, unused op only reports status
		send_item(OP_READ, '0, '0, idle_len());
		send_item(OP_READ, '1, '1, idle_len());
		send_item(OP_UNUSED, '1, '1, idle_len());
		// front only: back value comes from the front stack's bottom
		send_item(OP_PUSH_FRONT, '1, '1, idle_len());
		send_item(OP_PUSH_FRONT, '0, '0, idle_len());
		send_item(OP_PUSH_FRONT, 32'hA5A5_A5A5, 9'h0AA, idle_len());
		send_item(OP_READ, '1, 9'd0, idle_len());
		send_item(OP_READ, '0, 9'd2, idle_len());
		send_item(OP_READ, '0, 9'd3, idle_len());
		// both sides populated
		send_item(OP_PUSH_BACK, 32'h1234_5678, 9'h155, idle_len());
		send_item(OP_PUSH_BACK, 32'h8000_0001, '1, idle_len());
		send_item(OP_READ, 32'h5A5A_5A5A, 9'd1, idle_len());
		send_item(OP_READ, '0, 9'd3, 0);
		send_item(OP_READ, '0, 9'd4, 0);
		send_item(OP_READ, '0, 9'd5, 0);
		send_item(OP_READ, '0, 9'h100, idle_len());
		send_item(OP_READ, '0, '1, idle_len());
		send_item(OP_UNUSED, 32'h0F0F_0F0F, 9'd1, idle_len());

		// random traffic, push-heavy so both sides overflow before the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				code = OP_PUSH_FRONT;
			else if (r < 80)
				code = OP_PUSH_BACK;
			else if (r < 95)
				code = OP_READ;
			else
				code = OP_UNUSED;
			total = front_sent + back_sent;
			r = $urandom_range(0, 99);
			if (total > 0 && r < 70)
				pos = POS_W'($urandom_range(0, total - 1));
			else if (r < 80)
				pos = POS_W'(total);
			else
				pos = POS_W'($urandom_range(0, 2 ** POS_W - 1));
			gap = (i >= 400 && i < 500) ? 0 : idle_len();
			send_item(code, pick_word(), pos, gap);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items in, %0d results checked, deque peaked at %0d entries",
				accepted_items, sb.results_seen, sb.peak_count);
		$display("%0d pushes dropped on a full side, %0d reads hit, %0d reads missed",
				sb.dropped_pushes, sb.hits, sb.missed_reads);
		if (sb.errors == 0)
			$display("two_stack_deque_top_tb: done, clean");
		else
			$display("two_stack_deque_top_tb: done, errors");
		$finish;
	end

endmodule
